### hw/rtl/tge_pkg.sv
// ----------------------------------------------------------------------------
// tge_pkg
// Shared types, constants and helpers of the touchpad gesture engine.
// ----------------------------------------------------------------------------
package tge_pkg;

    // Motion ramp and counter limits
    localparam logic [7:0] SPEED_MAX = 8'h80;
    localparam logic [7:0] SPEED_INC = 8'h04;
    localparam logic [7:0] COUNT_MAX = 8'hff;
    localparam logic [6:0] MOTION_MAX = 7'd127;

    // Tap button codes
    localparam logic [2:0] BTN_NONE  = 3'd0;
    localparam logic [2:0] BTN_LEFT  = 3'd1;
    localparam logic [2:0] BTN_RIGHT = 3'd2;

    // Request kinds
    localparam logic KIND_TICK   = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // Finger count codes
    localparam logic [1:0] FINGERS_NONE  = 2'd0;
    localparam logic [1:0] FINGERS_ONE   = 2'd1;
    localparam logic [1:0] FINGERS_TWO   = 2'd2;
    localparam logic [1:0] FINGERS_OTHER = 2'd3;

    // Register map: word index on paddr[4:2]
    localparam int unsigned PADDR_W = 5;
    localparam logic [2:0] REG_PRETAP_TICKS    = 3'd0;
    localparam logic [2:0] REG_CLICK_TICKS     = 3'd1;
    localparam logic [2:0] REG_TOUCH_TIMEOUT   = 3'd2;
    localparam logic [2:0] REG_DRAG_HYSTERESIS = 3'd3;
    localparam logic [2:0] REG_WHEEL_STEP      = 3'd4;
    localparam logic [2:0] REG_TAP_ENABLE      = 3'd5;
    localparam logic [2:0] REG_TAP_DISTANCE    = 3'd6;

    // One input request
    typedef struct packed {
        logic        kind;
        logic [1:0]  finger_count;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic        sample_valid;
        logic        touch_blocked;
        logic [2:0]  button_mask;
    } t_item;

    // One report
    typedef struct packed {
        logic signed [7:0] delta_x;
        logic signed [7:0] delta_y;
        logic signed [7:0] wheel;
        logic [2:0]        buttons;
    } t_result;

    // Configuration registers
    typedef struct packed {
        logic [7:0]  pretap_ticks;
        logic [7:0]  click_ticks;
        logic [7:0]  touch_timeout;
        logic [15:0] drag_hysteresis;
        logic [6:0]  wheel_step;
        logic        tap_enable;
        logic [7:0]  tap_distance;
    } t_cfg;

    // Clamp a coordinate difference to the speed limit and to +-127
    function automatic logic signed [7:0] clamp_motion(
        input logic signed [16:0] v,
        input logic [7:0]         lim
    );
        logic [6:0]         eff;
        logic signed [16:0] hi;
        logic signed [16:0] lo;
        logic signed [16:0] r;
        eff = (lim > {1'b0, MOTION_MAX}) ? MOTION_MAX : lim[6:0];
        hi  = $signed({10'd0, eff});
        lo  = -hi;
        if (v > hi) begin
            r = hi;
        end else if (v < lo) begin
            r = lo;
        end else begin
            r = v;
        end
        return r[7:0];
    endfunction

endpackage

### hw/rtl/tge_in_if.sv
// ----------------------------------------------------------------------------
// tge_in_if
// Request channel of the gesture engine: valid/ready plus sample fields.
// ----------------------------------------------------------------------------
interface tge_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [1:0]  finger_count;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic        sample_valid;
    logic        touch_blocked;
    logic [2:0]  button_mask;

    modport source (
        output valid, kind, finger_count, pos_x, pos_y, sample_valid,
               touch_blocked, button_mask,
        input  ready
    );
    modport sink (
        input  valid, kind, finger_count, pos_x, pos_y, sample_valid,
               touch_blocked, button_mask,
        output ready
    );
endinterface

### hw/rtl/tge_out_if.sv
// ----------------------------------------------------------------------------
// tge_out_if
// Report channel of the gesture engine: valid/ready plus mouse report.
// ----------------------------------------------------------------------------
interface tge_out_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] delta_x;
    logic signed [7:0] delta_y;
    logic signed [7:0] wheel;
    logic [2:0]        buttons;

    modport source (
        output valid, delta_x, delta_y, wheel, buttons,
        input  ready
    );
    modport sink (
        input  valid, delta_x, delta_y, wheel, buttons,
        output ready
    );
endinterface

### hw/rtl/touchpad_gesture_engine_core.sv
// ----------------------------------------------------------------------------
// touchpad_gesture_engine_core
// Turns touchpad tick samples into relative mouse reports (motion, wheel,
// tap buttons) with an APB register port for the gesture tuning values.
// ----------------------------------------------------------------------------
// The block takes one request per clock while no report request waits in the
// input register. A request is captured in an input register, from which a
// single state-update stage applies it to the gesture state and, for a report
// request, loads the report register, from which the report shows on o_out.
// Tick requests produce no report. Requests keep flowing while a finished
// report waits for o_out.ready; only a report request that finds the report
// register still full waits in the input register. The user must write the
// registers through APB only while the block is idle; no logic enforces it.
module touchpad_gesture_engine_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    tge_in_if.sink                       i_in,
    tge_out_if.source                    o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tge_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    tge_pkg::t_cfg r_cfg;
    logic [2:0]    reg_idx;
    logic          cfg_wr;

    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pretap_ticks    <= 8'd2;
            r_cfg.click_ticks     <= 8'd10;
            r_cfg.touch_timeout   <= 8'd8;
            r_cfg.drag_hysteresis <= 16'd16;
            r_cfg.wheel_step      <= 7'd1;
            r_cfg.tap_enable      <= 1'b1;
            r_cfg.tap_distance    <= 8'd10;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                tge_pkg::REG_PRETAP_TICKS:    r_cfg.pretap_ticks    <= pwdata[7:0];
                tge_pkg::REG_CLICK_TICKS:     r_cfg.click_ticks     <= pwdata[7:0];
                tge_pkg::REG_TOUCH_TIMEOUT:   r_cfg.touch_timeout   <= pwdata[7:0];
                tge_pkg::REG_DRAG_HYSTERESIS: r_cfg.drag_hysteresis <= pwdata[15:0];
                tge_pkg::REG_WHEEL_STEP:      r_cfg.wheel_step      <= pwdata[6:0];
                tge_pkg::REG_TAP_ENABLE:      r_cfg.tap_enable      <= pwdata[0];
                tge_pkg::REG_TAP_DISTANCE:    r_cfg.tap_distance    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        unique case (reg_idx)
            tge_pkg::REG_PRETAP_TICKS:    prdata = {24'd0, r_cfg.pretap_ticks};
            tge_pkg::REG_CLICK_TICKS:     prdata = {24'd0, r_cfg.click_ticks};
            tge_pkg::REG_TOUCH_TIMEOUT:   prdata = {24'd0, r_cfg.touch_timeout};
            tge_pkg::REG_DRAG_HYSTERESIS: prdata = {16'd0, r_cfg.drag_hysteresis};
            tge_pkg::REG_WHEEL_STEP:      prdata = {25'd0, r_cfg.wheel_step};
            tge_pkg::REG_TAP_ENABLE:      prdata = {31'd0, r_cfg.tap_enable};
            tge_pkg::REG_TAP_DISTANCE:    prdata = {24'd0, r_cfg.tap_distance};
            default:                      prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input register and stage handshake
    // ------------------------------------------------------------------
    logic           r_in_valid;
    tge_pkg::t_item r_in;
    logic           r_out_valid;
    tge_pkg::t_result r_out;
    logic           advance;
    logic           is_tick;
    logic           is_report;
    logic           in_fire;

    assign is_tick   = r_in_valid && (r_in.kind == tge_pkg::KIND_TICK);
    assign is_report = r_in_valid && (r_in.kind == tge_pkg::KIND_REPORT);
    // a tick never needs the report register
    assign advance   = is_tick || (is_report && (!r_out_valid || o_out.ready));
    assign i_in.ready = !r_in_valid || advance;
    assign in_fire    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in.kind          <= i_in.kind;
            r_in.finger_count  <= i_in.finger_count;
            r_in.pos_x         <= i_in.pos_x;
            r_in.pos_y         <= i_in.pos_y;
            r_in.sample_valid  <= i_in.sample_valid;
            r_in.touch_blocked <= i_in.touch_blocked;
            r_in.button_mask   <= i_in.button_mask;
        end
    end

    // ------------------------------------------------------------------
    // Gesture state
    // ------------------------------------------------------------------
    logic [1:0]  r_sample_fingers, n_sample_fingers;
    logic [15:0] r_sample_x, n_sample_x;
    logic [15:0] r_sample_y, n_sample_y;
    logic [1:0]  r_prev_fingers, n_prev_fingers;
    logic [15:0] r_prev_x, n_prev_x;
    logic [15:0] r_prev_y, n_prev_y;
    logic [15:0] r_start_x, n_start_x;
    logic [15:0] r_start_y, n_start_y;
    logic [7:0]  r_idle_count, n_idle_count;
    logic [7:0]  r_two_finger_count, n_two_finger_count;
    logic [7:0]  r_press_window, n_press_window;
    logic [7:0]  r_contact_timer, n_contact_timer;
    logic [7:0]  r_speed_limit, n_speed_limit;
    logic [2:0]  r_button_latch, n_button_latch;
    logic [2:0]  r_tap_request, n_tap_request;
    logic        r_sample_armed, n_sample_armed;
    tge_pkg::t_result n_out;

    // Tick arithmetic: counters after this tick
    logic [7:0]  tk_idle;
    logic        tk_at_timeout;
    logic [7:0]  tk_tfc_base;
    logic [7:0]  tk_tfc;
    logic [7:0]  tk_press;
    logic [7:0]  tk_contact;
    logic        tk_contact_one;

    assign tk_idle = (r_idle_count != tge_pkg::COUNT_MAX &&
                      r_in.finger_count == tge_pkg::FINGERS_NONE)
                     ? r_idle_count + 8'd1 : r_idle_count;
    assign tk_at_timeout = (tk_idle == r_cfg.touch_timeout);
    assign tk_tfc_base   = tk_at_timeout ? 8'd0 : r_two_finger_count;
    assign tk_tfc = (tk_tfc_base != tge_pkg::COUNT_MAX &&
                     r_in.finger_count == tge_pkg::FINGERS_TWO)
                    ? tk_tfc_base + 8'd1 : tk_tfc_base;
    assign tk_press   = (r_press_window != 8'd0) ? r_press_window - 8'd1 : 8'd0;
    assign tk_contact = (r_contact_timer != 8'd0) ? r_contact_timer - 8'd1 : 8'd0;
    assign tk_contact_one = (tk_contact == 8'd1);

    // Report arithmetic: motion, tap drift, wheel thresholds
    logic signed [16:0] rp_diff_x;
    logic signed [16:0] rp_diff_y;
    logic signed [7:0]  rp_dx;
    logic signed [7:0]  rp_dy;
    logic signed [17:0] rp_drift;
    logic [16:0]        rp_drift_abs;
    logic               rp_tap_close;
    logic [16:0]        rp_y_lo;
    logic [16:0]        rp_prev_lo;
    logic               rp_up;
    logic               rp_down;
    logic [7:0]         rp_step;
    logic [7:0]         rp_speed_base;

    assign rp_diff_x = $signed({1'b0, r_sample_x}) - $signed({1'b0, r_prev_x});
    assign rp_diff_y = $signed({1'b0, r_sample_y}) - $signed({1'b0, r_prev_y});
    assign rp_dx     = tge_pkg::clamp_motion(rp_diff_x, r_speed_limit);
    assign rp_dy     = tge_pkg::clamp_motion(rp_diff_y, r_speed_limit);

    assign rp_drift = $signed({2'd0, r_start_x}) + $signed({2'd0, r_start_y})
                    - $signed({2'd0, r_sample_x}) - $signed({2'd0, r_sample_y});
    assign rp_drift_abs = rp_drift[17] ? 17'(-rp_drift) : rp_drift[16:0];
    assign rp_tap_close = (rp_drift_abs < {9'd0, r_cfg.tap_distance});

    assign rp_y_lo    = {1'b0, r_sample_y} + {1'b0, r_cfg.drag_hysteresis};
    assign rp_prev_lo = {1'b0, r_prev_y} + {1'b0, r_cfg.drag_hysteresis};
    assign rp_up      = ({1'b0, r_prev_y} > rp_y_lo);
    assign rp_down    = (rp_prev_lo < {1'b0, r_sample_y});
    assign rp_step    = {1'b0, r_cfg.wheel_step};

    // speed limit restarts on a fresh contact or after two fingers
    assign rp_speed_base = (r_prev_fingers == tge_pkg::FINGERS_NONE ||
                            r_prev_fingers == tge_pkg::FINGERS_TWO)
                           ? 8'd0 : r_speed_limit;

    // State update for the request in the input register
    always_comb begin
        n_sample_fingers   = r_sample_fingers;
        n_sample_x         = r_sample_x;
        n_sample_y         = r_sample_y;
        n_prev_fingers     = r_prev_fingers;
        n_prev_x           = r_prev_x;
        n_prev_y           = r_prev_y;
        n_start_x          = r_start_x;
        n_start_y          = r_start_y;
        n_idle_count       = r_idle_count;
        n_two_finger_count = r_two_finger_count;
        n_press_window     = r_press_window;
        n_contact_timer    = r_contact_timer;
        n_speed_limit      = r_speed_limit;
        n_button_latch     = r_button_latch;
        n_tap_request      = r_tap_request;
        n_sample_armed     = r_sample_armed;
        n_out.delta_x      = 8'sd0;
        n_out.delta_y      = 8'sd0;
        n_out.wheel        = 8'sd0;
        n_out.buttons      = r_button_latch | r_in.button_mask;

        if (advance && is_tick) begin
            // store sample, run counters
            n_sample_fingers   = r_in.finger_count;
            n_sample_x         = r_in.pos_x;
            n_sample_y         = r_in.pos_y;
            n_idle_count       = tk_idle;
            n_two_finger_count = tk_tfc;
            n_press_window     = tk_press;
            n_contact_timer    = tk_contact;
            if (r_in.sample_valid && !r_in.touch_blocked) begin
                n_sample_armed = 1'b1;
            end
            if (tk_at_timeout && r_cfg.tap_enable) begin
                n_button_latch = r_tap_request;
                n_tap_request  = tge_pkg::BTN_NONE;
            end
            if (tk_contact_one) begin
                n_prev_x = 16'd0;
                n_prev_y = 16'd0;
                if (tk_press != 8'd0) begin
                    n_sample_armed = 1'b1;
                end else begin
                    n_prev_fingers = tge_pkg::FINGERS_NONE;
                end
            end
        end else if (advance && is_report) begin
            n_button_latch = tge_pkg::BTN_NONE;
            if (r_sample_armed) begin
                unique case (r_sample_fingers)
                    tge_pkg::FINGERS_NONE: begin
                        // lift: maybe a tap
                        if (r_prev_fingers != tge_pkg::FINGERS_NONE) begin
                            if (r_idle_count > r_cfg.pretap_ticks && rp_tap_close) begin
                                n_tap_request = (r_two_finger_count != 8'd0)
                                                ? tge_pkg::BTN_RIGHT : tge_pkg::BTN_LEFT;
                            end
                            n_idle_count = 8'd0;
                        end
                        n_speed_limit = 8'd0;
                        n_prev_x      = 16'd0;
                        n_prev_y      = 16'd0;
                    end
                    tge_pkg::FINGERS_ONE: begin
                        // pointer motion
                        n_contact_timer = r_cfg.touch_timeout;
                        if (r_prev_fingers == tge_pkg::FINGERS_NONE) begin
                            n_press_window = r_cfg.click_ticks;
                        end
                        if (r_prev_fingers == tge_pkg::FINGERS_ONE &&
                            r_prev_x != 16'd0) begin
                            n_out.delta_x = rp_dx;
                            n_out.delta_y = rp_dy;
                        end
                        if (r_prev_fingers != tge_pkg::FINGERS_ONE) begin
                            n_start_x = r_sample_x;
                            n_start_y = r_sample_y;
                        end
                        n_prev_x      = r_sample_x;
                        n_prev_y      = r_sample_y;
                        n_speed_limit = (rp_speed_base < tge_pkg::SPEED_MAX)
                                        ? rp_speed_base + tge_pkg::SPEED_INC
                                        : rp_speed_base;
                    end
                    tge_pkg::FINGERS_TWO: begin
                        // scroll
                        if (r_prev_fingers == tge_pkg::FINGERS_NONE) begin
                            n_contact_timer = r_cfg.touch_timeout;
                        end
                        if (r_prev_fingers == tge_pkg::FINGERS_TWO) begin
                            if (rp_up) begin
                                n_out.wheel = rp_step;
                            end else if (rp_down) begin
                                n_out.wheel = -rp_step;
                            end
                            if ((rp_up || rp_down) && rp_step != 8'd0) begin
                                n_idle_count = 8'd0;
                            end
                            n_press_window = 8'd0;
                        end else begin
                            n_two_finger_count = 8'd0;
                            n_start_x          = r_sample_x;
                            n_start_y          = r_sample_y;
                        end
                        n_prev_x = r_sample_x;
                        n_prev_y = r_sample_y;
                    end
                    default: begin
                        n_prev_x = 16'd0;
                        n_prev_y = 16'd0;
                    end
                endcase
                n_prev_fingers = r_sample_fingers;
                n_sample_armed = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_fingers   <= 2'd0;
            r_sample_x         <= 16'd0;
            r_sample_y         <= 16'd0;
            r_prev_fingers     <= 2'd0;
            r_prev_x           <= 16'd0;
            r_prev_y           <= 16'd0;
            r_start_x          <= 16'd0;
            r_start_y          <= 16'd0;
            r_idle_count       <= 8'd0;
            r_two_finger_count <= 8'd0;
            r_press_window     <= 8'd0;
            r_contact_timer    <= 8'd0;
            r_speed_limit      <= 8'd0;
            r_button_latch     <= 3'd0;
            r_tap_request      <= 3'd0;
            r_sample_armed     <= 1'b0;
        end else begin
            r_sample_fingers   <= n_sample_fingers;
            r_sample_x         <= n_sample_x;
            r_sample_y         <= n_sample_y;
            r_prev_fingers     <= n_prev_fingers;
            r_prev_x           <= n_prev_x;
            r_prev_y           <= n_prev_y;
            r_start_x          <= n_start_x;
            r_start_y          <= n_start_y;
            r_idle_count       <= n_idle_count;
            r_two_finger_count <= n_two_finger_count;
            r_press_window     <= n_press_window;
            r_contact_timer    <= n_contact_timer;
            r_speed_limit      <= n_speed_limit;
            r_button_latch     <= n_button_latch;
            r_tap_request      <= n_tap_request;
            r_sample_armed     <= n_sample_armed;
        end
    end

    // ------------------------------------------------------------------
    // Report register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && is_report) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && is_report) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.delta_x = r_out.delta_x;
    assign o_out.delta_y = r_out.delta_y;
    assign o_out.wheel   = r_out.wheel;
    assign o_out.buttons = r_out.buttons;

endmodule

### hw/rtl/tge_checker.sv
// ----------------------------------------------------------------------------
// tge_checker
// Port-level checks of the gesture engine, bound to the top level.
// ----------------------------------------------------------------------------
module tge_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic signed [7:0] i_delta_x,
    input logic signed [7:0] i_delta_y,
    input logic signed [7:0] i_wheel,
    input logic [2:0]        i_buttons,
    input logic              i_pready
);

    // No report right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("report valid after reset");

    // A stalled report holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_delta_x) &&
        $stable(i_delta_y) && $stable(i_wheel) && $stable(i_buttons))
        else $error("stalled report changed");

    // Saturation never yields -128
    a_saturate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_delta_x != 8'sh80 && i_delta_y != 8'sh80 &&
        i_wheel != 8'sh80)
        else $error("report field out of range");

    // Pointer motion and wheel come from different finger counts
    a_motion_xor_wheel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_wheel == 8'sd0 || (i_delta_x == 8'sd0 && i_delta_y == 8'sd0))
        else $error("motion and wheel in one report");

    // APB never waits
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pready)
        else $error("pready low");

endmodule

bind touchpad_gesture_engine_core tge_checker u_tge_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_delta_x   (o_out.delta_x),
    .i_delta_y   (o_out.delta_y),
    .i_wheel     (o_out.wheel),
    .i_buttons   (o_out.buttons),
    .i_pready    (pready)
);

### dv/touchpad_gesture_engine_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touchpad_gesture_engine_core_tb
// Drives tick and report requests into the gesture engine and checks every
// mouse report against a cycle-free model of the gesture state. Register
// settings change between phases over APB: reset values, minimums, maximums
// and random tunings. Most requests come as touch, lift, swipe and scroll
// gestures, with noise mixed in. Both channels idle at random, and the
// report side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module touchpad_gesture_engine_core_tb;

    localparam int IDLE_GAP    = 8;     // cycles for a tick to drain
    localparam int HOLDOFF_LEN = 400;   // long report back-pressure
    localparam int STALL_LIMIT = 3000;  // cycles without progress

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [tge_pkg::PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    tge_in_if  in_ch ();
    tge_out_if out_ch ();

    touchpad_gesture_engine_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Request and report stores
    tge_pkg::t_item   request_q[$];
    tge_pkg::t_result expected_reports[$];
    tge_pkg::t_item   on_bus;
    tge_pkg::t_result want;

    // Settings as the model sees them
    tge_pkg::t_cfg pcfg = '{pretap_ticks: 8'd2, click_ticks: 8'd10, touch_timeout: 8'd8,
                            drag_hysteresis: 16'd16, wheel_step: 7'd1, tap_enable: 1'b1,
                            tap_distance: 8'd10};

    // Gesture state of the model
    logic [1:0]  smp_fingers = '0;
    logic [15:0] smp_x = '0;
    logic [15:0] smp_y = '0;
    logic [1:0]  last_fingers = '0;
    logic [15:0] last_x = '0;
    logic [15:0] last_y = '0;
    logic [15:0] origin_x = '0;
    logic [15:0] origin_y = '0;
    logic [7:0]  idle_cnt = '0;
    logic [7:0]  two_cnt = '0;
    logic [7:0]  press_win = '0;
    logic [7:0]  contact_tmr = '0;
    logic [7:0]  speed_lim = '0;
    logic [2:0]  btn_latch = '0;
    logic [2:0]  tap_req = '0;
    logic        armed = 1'b0;

    // Bookkeeping
    int items_queued = 0;
    int n_ticks = 0;
    int n_reports = 0;
    int n_motion = 0;
    int n_wheel = 0;
    int n_taps = 0;
    int n_settings = 0;
    int mismatches = 0;
    int reg_errors = 0;

    // Sender and receiver pacing
    int  burst_left = 0;
    int  gap_left = 0;
    int  rx_mode = 0;
    int  rx_left = 0;
    int  holdoff_left = 0;
    bit  holdoff_done = 1'b0;
    bit  pressure_on = 1'b0;
    bit  take;
    int  stall_cycles = 0;

    // Position walked by the gesture generator
    logic [15:0] walk_x = 16'd30000;
    logic [15:0] walk_y = 16'd30000;

    // Motion clamp: speed limit first, then the 8-bit range
    function automatic int limit_motion(int v);
        int lim;
        lim = int'(speed_lim);
        if (v > lim) v = lim;
        if (v < -lim) v = -lim;
        if (v > 127) v = 127;
        if (v < -127) v = -127;
        return v;
    endfunction

    // Apply one accepted request to the gesture state; reports are queued
    function automatic void advance_gesture_state(input tge_pkg::t_item r);
        int x, y, px, py, ox, oy, hy, wstep, tdist, d, dx, dy, wh;
        tge_pkg::t_result rep;
        if (r.kind == tge_pkg::KIND_TICK) begin
            n_ticks++;
            smp_fingers = r.finger_count;
            smp_x = r.pos_x;
            smp_y = r.pos_y;
            if (!r.touch_blocked && r.sample_valid) armed = 1'b1;
            if (idle_cnt != tge_pkg::COUNT_MAX && smp_fingers == tge_pkg::FINGERS_NONE)
                idle_cnt++;
            // timeout: a pending tap moves into the button latch
            if (idle_cnt == pcfg.touch_timeout) begin
                if (pcfg.tap_enable) begin
                    btn_latch = tap_req;
                    tap_req = tge_pkg::BTN_NONE;
                end
                two_cnt = '0;
            end
            if (two_cnt != tge_pkg::COUNT_MAX && smp_fingers == tge_pkg::FINGERS_TWO)
                two_cnt++;
            if (press_win != 0) press_win--;
            if (contact_tmr != 0) contact_tmr--;
            // contact timeout
            if (contact_tmr == 1) begin
                last_x = '0;
                last_y = '0;
                if (press_win != 0) armed = 1'b1;
                else last_fingers = tge_pkg::FINGERS_NONE;
            end
        end else begin
            dx = 0;
            dy = 0;
            wh = 0;
            x = int'(smp_x);
            y = int'(smp_y);
            px = int'(last_x);
            py = int'(last_y);
            ox = int'(origin_x);
            oy = int'(origin_y);
            hy = int'(pcfg.drag_hysteresis);
            wstep = int'(pcfg.wheel_step);
            tdist = int'(pcfg.tap_distance);
            rep.buttons = btn_latch | r.button_mask;
            if (btn_latch != tge_pkg::BTN_NONE) n_taps++;
            if (armed) begin
                case (smp_fingers)
                    tge_pkg::FINGERS_NONE: begin
                        // lift: maybe a tap
                        if (last_fingers != tge_pkg::FINGERS_NONE) begin
                            if (idle_cnt > pcfg.pretap_ticks) begin
                                d = ox + oy - x - y;
                                if (d < 0) d = -d;
                                if (d < tdist)
                                    tap_req = (two_cnt != 0) ? tge_pkg::BTN_RIGHT
                                                             : tge_pkg::BTN_LEFT;
                            end
                            idle_cnt = '0;
                        end
                        speed_lim = '0;
                        last_x = '0;
                        last_y = '0;
                    end
                    tge_pkg::FINGERS_ONE: begin
                        contact_tmr = pcfg.touch_timeout;
                        if (last_fingers == tge_pkg::FINGERS_NONE) begin
                            press_win = pcfg.click_ticks;
                            speed_lim = '0;
                        end else if (last_fingers == tge_pkg::FINGERS_ONE) begin
                            if (last_x != 0) begin
                                dx = limit_motion(x - px);
                                dy = limit_motion(y - py);
                            end
                        end else if (last_fingers == tge_pkg::FINGERS_TWO) begin
                            speed_lim = '0;
                        end
                        if (last_fingers != tge_pkg::FINGERS_ONE) begin
                            origin_x = smp_x;
                            origin_y = smp_y;
                        end
                        last_x = smp_x;
                        last_y = smp_y;
                        if (speed_lim < tge_pkg::SPEED_MAX) speed_lim += tge_pkg::SPEED_INC;
                    end
                    tge_pkg::FINGERS_TWO: begin
                        if (last_fingers == tge_pkg::FINGERS_NONE)
                            contact_tmr = pcfg.touch_timeout;
                        if (last_fingers == tge_pkg::FINGERS_TWO) begin
                            if (py > y + hy) wh = wstep;
                            else if (py + hy < y) wh = -wstep;
                            if (wh != 0) idle_cnt = '0;
                            press_win = '0;
                        end else begin
                            two_cnt = '0;
                            origin_x = smp_x;
                            origin_y = smp_y;
                        end
                        last_x = smp_x;
                        last_y = smp_y;
                    end
                    default: begin
                        last_x = '0;
                        last_y = '0;
                    end
                endcase
                last_fingers = smp_fingers;
                armed = 1'b0;
            end
            rep.delta_x = dx[7:0];
            rep.delta_y = dy[7:0];
            rep.wheel = wh[7:0];
            btn_latch = tge_pkg::BTN_NONE;
            expected_reports.push_back(rep);
            n_reports++;
            if (dx != 0 || dy != 0) n_motion++;
            if (wh != 0) n_wheel++;
        end
    endfunction

    // Driver: bursts of requests with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                advance_gesture_state(on_bus);
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_ch.valid <= 1'b0;
                end else if (request_q.size() > 0) begin
                    on_bus = request_q.pop_front();
                    in_ch.kind          <= on_bus.kind;
                    in_ch.finger_count  <= on_bus.finger_count;
                    in_ch.pos_x         <= on_bus.pos_x;
                    in_ch.pos_y         <= on_bus.pos_y;
                    in_ch.sample_valid  <= on_bus.sample_valid;
                    in_ch.touch_blocked <= on_bus.touch_blocked;
                    in_ch.button_mask   <= on_bus.button_mask;
                    in_ch.valid         <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        case ($urandom_range(0, 9))
                            0: begin
                                burst_left = $urandom_range(30, 80);
                                gap_left = 0;
                            end
                            1: begin
                                burst_left = $urandom_range(1, 4);
                                gap_left = $urandom_range(12, 40);
                            end
                            default: begin
                                burst_left = $urandom_range(1, 12);
                                gap_left = $urandom_range(0, 5);
                            end
                        endcase
                    end
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: report checks and receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_reports.size() == 0) begin
                    $error("unexpected report: dx %0d dy %0d wheel %0d buttons %0d",
                           out_ch.delta_x, out_ch.delta_y, out_ch.wheel, out_ch.buttons);
                    mismatches++;
                end else begin
                    want = expected_reports.pop_front();
                    if (out_ch.delta_x !== want.delta_x) begin
                        $error("delta_x: expected %0d, got %0d", want.delta_x, out_ch.delta_x);
                        mismatches++;
                    end
                    if (out_ch.delta_y !== want.delta_y) begin
                        $error("delta_y: expected %0d, got %0d", want.delta_y, out_ch.delta_y);
                        mismatches++;
                    end
                    if (out_ch.wheel !== want.wheel) begin
                        $error("wheel: expected %0d, got %0d", want.wheel, out_ch.wheel);
                        mismatches++;
                    end
                    if (out_ch.buttons !== want.buttons) begin
                        $error("buttons: expected %0d, got %0d", want.buttons, out_ch.buttons);
                        mismatches++;
                    end
                end
            end
            // one long hold-off when asked, else a changing stall pattern
            if (pressure_on && !holdoff_done) begin
                holdoff_left = HOLDOFF_LEN;
                holdoff_done = 1'b1;
            end
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(10, 150);
            end
            rx_left--;
            if (holdoff_left > 0) begin
                holdoff_left--;
                take = 1'b0;
            end else begin
                case (rx_mode)
                    0: take = 1'b1;
                    1: take = $urandom_range(0, 1);
                    2: take = ($urandom_range(0, 4) != 0);
                    default: take = ($urandom_range(0, 9) == 0);
                endcase
            end
            out_ch.ready <= take;
        end
    end

    // Watchdog: no request, report or register access for too long
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $error("no progress for %0d cycles, %0d reports outstanding",
                   STALL_LIMIT, expected_reports.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // APB write, then read back
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        logic [31:0] got;
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        // write taken here; psel stays up for the readback setup
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        got = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (got !== val) begin
            $error("register %0d readback: expected %0h, got %0h", idx, val, got);
            reg_errors++;
        end
    endtask

    task automatic load_settings(input tge_pkg::t_cfg c);
        write_reg(tge_pkg::REG_PRETAP_TICKS, 32'(c.pretap_ticks));
        write_reg(tge_pkg::REG_CLICK_TICKS, 32'(c.click_ticks));
        write_reg(tge_pkg::REG_TOUCH_TIMEOUT, 32'(c.touch_timeout));
        write_reg(tge_pkg::REG_DRAG_HYSTERESIS, 32'(c.drag_hysteresis));
        write_reg(tge_pkg::REG_WHEEL_STEP, 32'(c.wheel_step));
        write_reg(tge_pkg::REG_TAP_ENABLE, 32'(c.tap_enable));
        write_reg(tge_pkg::REG_TAP_DISTANCE, 32'(c.tap_distance));
        pcfg = c;
        n_settings++;
    endtask

    // Wait until every request is in, every report out, and ticks drained
    task automatic settle_idle();
        while (request_q.size() != 0 || in_ch.valid || expected_reports.size() != 0)
            @(posedge i_clk);
        repeat (IDLE_GAP) @(posedge i_clk);
    endtask

    task automatic queue_request(input logic k, input logic [1:0] f, input logic [15:0] x,
                                 input logic [15:0] y, input logic vld, input logic blk,
                                 input logic [2:0] mask);
        tge_pkg::t_item it;
        it.kind = k;
        it.finger_count = f;
        it.pos_x = x;
        it.pos_y = y;
        it.sample_valid = vld;
        it.touch_blocked = blk;
        it.button_mask = mask;
        request_q.push_back(it);
        items_queued++;
    endtask

    function automatic logic [2:0] pick_mask();
        return ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'b000;
    endfunction

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(0, 15))
            0: return 16'h0000;
            1: return 16'hffff;
            2, 3: return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(2000, 63000));
        endcase
    endfunction

    function automatic int jitter(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // Tick count around a register value; long runs only now and then
    function automatic int idle_span(logic [7:0] lim);
        if (lim <= 30 || $urandom_range(0, 11) == 0) return int'(lim) + 3;
        return int'($urandom_range(5, 30));
    endfunction

    // One sensor sample, reported with the given chance in percent
    task automatic queue_frame(input logic [1:0] f, input logic [15:0] x, input logic [15:0] y,
                               input int pct);
        queue_request(tge_pkg::KIND_TICK, f, x, y, $urandom_range(0, 15) != 0,
                      $urandom_range(0, 23) == 0, pick_mask());
        if ($urandom_range(1, 100) <= pct)
            queue_request(tge_pkg::KIND_REPORT, 2'($urandom_range(0, 3)), pick_coord(),
                          pick_coord(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          pick_mask());
    endtask

    // One random gesture
    task automatic queue_gesture();
        int pick, n, span, hy;
        logic [1:0] fc;
        pick = $urandom_range(0, 9);
        if (pick <= 5) begin
            // touch and lift; small drift makes a tap
            fc = ($urandom_range(0, 3) == 0) ? tge_pkg::FINGERS_TWO : tge_pkg::FINGERS_ONE;
            if ($urandom_range(0, 4) == 0) begin
                walk_x = pick_coord();
                walk_y = pick_coord();
            end
            span = ($urandom_range(0, 2) == 0) ? 40 : 3;
            n = $urandom_range(1, 5);
            repeat (n) begin
                walk_x = 16'(int'(walk_x) + jitter(span));
                walk_y = 16'(int'(walk_y) + jitter(span));
                queue_frame(fc, walk_x, walk_y, 80);
            end
            // contact held without reports runs the contact timer out
            if ($urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, idle_span(pcfg.touch_timeout));
                repeat (n) queue_frame(fc, walk_x, walk_y, 0);
            end
            n = $urandom_range(0, idle_span(pcfg.pretap_ticks));
            repeat (n) queue_frame(tge_pkg::FINGERS_NONE, walk_x, walk_y, 0);
            queue_frame(tge_pkg::FINGERS_NONE, 16'(int'(walk_x) + jitter(span)),
                        16'(int'(walk_y) + jitter(span)), 100);
            // idle through the timeout so a pending tap shows up
            n = idle_span(pcfg.touch_timeout);
            repeat (n) queue_frame(tge_pkg::FINGERS_NONE, walk_x, walk_y, 25);
            queue_request(tge_pkg::KIND_REPORT, tge_pkg::FINGERS_NONE, walk_x, walk_y,
                          1'b0, 1'b0, pick_mask());
        end else if (pick <= 7) begin
            // one-finger swipe, long enough to ramp the speed limit
            case ($urandom_range(0, 2))
                0: span = 3;
                1: span = 30;
                default: span = 300;
            endcase
            n = $urandom_range(8, 40);
            repeat (n) begin
                walk_x = 16'(int'(walk_x) + jitter(span));
                walk_y = 16'(int'(walk_y) + jitter(span));
                queue_frame(tge_pkg::FINGERS_ONE, walk_x, walk_y, 100);
            end
        end else if (pick == 8) begin
            // two-finger scroll around the hysteresis
            hy = int'(pcfg.drag_hysteresis);
            span = (hy > 15000) ? 30000 : 2 * hy + 8;
            n = $urandom_range(3, 10);
            repeat (n) begin
                walk_x = 16'(int'(walk_x) + jitter(3));
                walk_y = 16'(int'(walk_y) + jitter(span));
                queue_frame(tge_pkg::FINGERS_TWO, walk_x, walk_y, 90);
            end
        end else begin
            // noise
            n = $urandom_range(1, 4);
            repeat (n)
                queue_request(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                              16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              3'($urandom_range(0, 7)));
        end
    endtask

    // Stimulus and run control
    initial begin
        tge_pkg::t_cfg c;
        int goal;
        in_ch.valid = 1'b0;
        in_ch.kind = tge_pkg::KIND_TICK;
        in_ch.finger_count = tge_pkg::FINGERS_NONE;
        in_ch.pos_x = '0;
        in_ch.pos_y = '0;
        in_ch.sample_valid = 1'b0;
        in_ch.touch_blocked = 1'b0;
        in_ch.button_mask = '0;
        out_ch.ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: unarmed report with all physical buttons
        queue_request(tge_pkg::KIND_REPORT, tge_pkg::FINGERS_OTHER, 16'hffff, 16'hffff,
                      1'b1, 1'b1, 3'b111);
        // first touch, then a jump clamped by the speed limit
        queue_request(tge_pkg::KIND_TICK, tge_pkg::FINGERS_ONE, 16'd1000, 16'd1000,
                      1'b1, 1'b0, 3'b000);
        queue_request(tge_pkg::KIND_REPORT, tge_pkg::FINGERS_NONE, '0, '0, 1'b0, 1'b0, 3'b000);
        queue_request(tge_pkg::KIND_TICK, tge_pkg::FINGERS_ONE, 16'd0, 16'd0,
                      1'b1, 1'b0, 3'b001);
        queue_request(tge_pkg::KIND_REPORT, tge_pkg::FINGERS_NONE, '0, '0, 1'b0, 1'b0, 3'b000);
        // blocked sample, then no motion after a zero previous x
        queue_request(tge_pkg::KIND_TICK, tge_pkg::FINGERS_ONE, 16'hffff, 16'hffff,
                      1'b1, 1'b1, 3'b000);
        queue_request(tge_pkg::KIND_TICK, tge_pkg::FINGERS_ONE, 16'hffff, 16'hffff,
                      1'b1, 1'b0, 3'b000);
        queue_request(tge_pkg::KIND_REPORT, tge_pkg::FINGERS_NONE, '0, '0, 1'b0, 1'b0, 3'b010);
        // other finger count
        queue_request(tge_pkg::KIND_TICK, tge_pkg::FINGERS_OTHER, 16'd1234, 16'd4321,
                      1'b1, 1'b0, 3'b000);
        queue_request(tge_pkg::KIND_REPORT, tge_pkg::FINGERS_NONE, '0, '0, 1'b0, 1'b0, 3'b000);
        // two fingers: wheel up, wheel down
        queue_request(tge_pkg::KIND_TICK, tge_pkg::FINGERS_TWO, 16'd5000, 16'd5000,
                      1'b1, 1'b0, 3'b000);
        queue_request(tge_pkg::KIND_REPORT, tge_pkg::FINGERS_NONE, '0, '0, 1'b0, 1'b0, 3'b000);
        queue_request(tge_pkg::KIND_TICK, tge_pkg::FINGERS_TWO, 16'd5000, 16'd4000,
                      1'b1, 1'b0, 3'b000);
        queue_request(tge_pkg::KIND_REPORT, tge_pkg::FINGERS_NONE, '0, '0, 1'b0, 1'b0, 3'b000);
        queue_request(tge_pkg::KIND_TICK, tge_pkg::FINGERS_TWO, 16'd5000, 16'd6000,
                      1'b1, 1'b0, 3'b000);
        queue_request(tge_pkg::KIND_REPORT, tge_pkg::FINGERS_NONE, '0, '0, 1'b0, 1'b0, 3'b000);
        // lift close to the start: right tap, released at the timeout
        repeat (2)
            queue_request(tge_pkg::KIND_TICK, tge_pkg::FINGERS_NONE, '0, '0,
                          1'b0, 1'b0, 3'b000);
        queue_request(tge_pkg::KIND_TICK, tge_pkg::FINGERS_NONE, 16'd5000, 16'd5003,
                      1'b1, 1'b0, 3'b000);
        queue_request(tge_pkg::KIND_REPORT, tge_pkg::FINGERS_NONE, '0, '0, 1'b0, 1'b0, 3'b000);
        repeat (8)
            queue_request(tge_pkg::KIND_TICK, tge_pkg::FINGERS_NONE, 16'd5000, 16'd5003,
                          1'b0, 1'b0, 3'b000);
        queue_request(tge_pkg::KIND_REPORT, tge_pkg::FINGERS_NONE, '0, '0, 1'b0, 1'b0, 3'b000);

        goal = items_queued + 300;
        while (items_queued < goal) queue_gesture();

        // later phases: minimums, maximums, then random tunings
        for (int ph = 1; ph < 6; ph++) begin
            settle_idle();
            case (ph)
                1: c = '{pretap_ticks: 8'd0, click_ticks: 8'd0, touch_timeout: 8'd2,
                         drag_hysteresis: 16'd0, wheel_step: 7'd1, tap_enable: 1'b0,
                         tap_distance: 8'd0};
                2: c = '{pretap_ticks: 8'd255, click_ticks: 8'd255, touch_timeout: 8'd255,
                         drag_hysteresis: 16'hffff, wheel_step: 7'd127, tap_enable: 1'b1,
                         tap_distance: 8'd255};
                default: begin
                    c.pretap_ticks = 8'($urandom_range(0, 6));
                    c.click_ticks = 8'($urandom_range(0, 40));
                    c.touch_timeout = 8'($urandom_range(2, 16));
                    c.drag_hysteresis = 16'($urandom_range(0, 80));
                    c.wheel_step = 7'($urandom_range(1, 127));
                    c.tap_enable = 1'($urandom_range(0, 1));
                    c.tap_distance = 8'($urandom_range(0, 80));
                end
            endcase
            load_settings(c);
            if (ph == 3) pressure_on = 1'b1;
            goal = items_queued + 320;
            while (items_queued < goal) queue_gesture();
        end

        settle_idle();
        $display("Covered %0d ticks and %0d reports over %0d register settings plus reset values",
                 n_ticks, n_reports, n_settings);
        $display("Reports with motion: %0d, with wheel steps: %0d, with tap buttons: %0d",
                 n_motion, n_wheel, n_taps);
        if (mismatches == 0 && reg_errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
